### hw/rtl/adsr_envelope_generator_defines.svh
// Assertion macros shared by the envelope generator RTL.
// Depends on nothing; included by the top level only.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ADSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ADSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/adsr_pkg.sv
// Shared types and constants of the ADSR envelope generator.
// No dependencies; used by the interfaces and every module but adsr_div.
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int TICK_BITS   = 20;
    localparam int MIN_TIME_US = 100;
    localparam int PHASE_BITS  = 3;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_TIME   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_TIME    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_TIME  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_LEVEL    = 3'd4;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_MUL   = 2'd1,
        SEQ_DIV   = 2'd2,
        SEQ_APPLY = 2'd3
    } t_seq_state;

endpackage

### hw/rtl/adsr_in_if.sv
// Request channel of the envelope generator: gate and elapsed tick time.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

interface adsr_in_if;
    logic                             valid;
    logic                             ready;
    logic                             gate;
    logic [adsr_pkg::TICK_BITS-1:0]   tick_time;

    modport source (output valid, output gate, output tick_time, input ready);
    modport sink   (input valid, input gate, input tick_time, output ready);
endinterface

### hw/rtl/adsr_out_if.sv
// Result channel of the envelope generator: level and phase.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

interface adsr_out_if #(
    parameter int LEVEL_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic [LEVEL_BITS-1:0]             level;
    logic [adsr_pkg::PHASE_BITS-1:0]   phase;

    modport source (output valid, output level, output phase, input ready);
    modport sink   (input valid, input level, input phase, output ready);
endinterface

### hw/rtl/adsr_div.sv
// Iterative restoring divider, one quotient bit per clock.
// Standalone; instantiated by adsr_envelope_generator.
`timescale 1ns / 1ps

module adsr_div #(
    parameter int DW = 36,
    parameter int VW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_quo;
    logic [VW-1:0] n_rem;

    // Shift in the next dividend bit, try the subtract
    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = ~w_diff[VW];
        n_quo   = {r_quo[DW-2:0], w_ge};
        n_rem   = w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hw/rtl/adsr_envelope_generator.sv
// Linear ADSR envelope generator: one request per tick, one level/phase result.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if, adsr_div and the defines header.
//
// Each request carries a gate bit and the microseconds elapsed since the
// previous tick; the block answers with the new envelope level (unsigned
// Q0.LEVEL_BITS) and phase (0 idle, 1 attack, 2 decay, 3 sustain, 4 release).
// From acceptance to the next acceptance the sequencer steps through its
// states in order: SEQ_MUL forms the product tick_time * span and starts the
// shared restoring divider, SEQ_DIV waits while it finds one quotient bit per
// clock (TICK_BITS + LEVEL_BITS bits), SEQ_APPLY updates the envelope state
// once the output register is free, and SEQ_IDLE takes the next request. The
// result sits in an output register, so the next request is taken while it
// still waits to be read. Ready drops for the whole computation. Configuration
// is written through i_cfg_we / i_cfg_idx / i_cfg_data and must only change
// while no request is in flight; indexes past the last register are dropped.
// Times below 100 us act as 100 us.
`timescale 1ns / 1ps
`include "adsr_envelope_generator_defines.svh"

module adsr_envelope_generator #(
    parameter int LEVEL_BITS = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] i_cfg_data,
    adsr_in_if.sink                                 i_req,
    adsr_out_if.source                              o_rsp
);

    localparam int TB = adsr_pkg::TICK_BITS;
    localparam int DW = TB + LEVEL_BITS;   // product / dividend width
    localparam logic [LEVEL_BITS-1:0] FullScale = '1;
    localparam logic [TIME_BITS-1:0]  MinTime   = TIME_BITS'(adsr_pkg::MIN_TIME_US);

    // ---------------- configuration registers ----------------
    logic [TIME_BITS-1:0]  r_attack_time;
    logic [TIME_BITS-1:0]  r_decay_time;
    logic [LEVEL_BITS-1:0] r_sustain;
    logic [TIME_BITS-1:0]  r_release_time;
    logic [LEVEL_BITS-1:0] r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_time  <= TIME_BITS'(10000);
            r_decay_time   <= TIME_BITS'(100000);
            r_sustain      <= LEVEL_BITS'(45875);
            r_release_time <= TIME_BITS'(200000);
            r_peak         <= LEVEL_BITS'(65535);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adsr_pkg::CFG_ATTACK_TIME:   r_attack_time  <= i_cfg_data[TIME_BITS-1:0];
                adsr_pkg::CFG_DECAY_TIME:    r_decay_time   <= i_cfg_data[TIME_BITS-1:0];
                adsr_pkg::CFG_SUSTAIN_LEVEL: r_sustain      <= i_cfg_data[LEVEL_BITS-1:0];
                adsr_pkg::CFG_RELEASE_TIME:  r_release_time <= i_cfg_data[TIME_BITS-1:0];
                adsr_pkg::CFG_PEAK_LEVEL:    r_peak         <= i_cfg_data[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer and envelope state ----------------
    adsr_pkg::t_seq_state r_state, n_state;
    adsr_pkg::t_phase     r_phase;       // committed phase
    logic [LEVEL_BITS-1:0] r_level;      // committed level
    adsr_pkg::t_phase     r_work_phase;  // phase after the gate decision
    logic [TB-1:0]        r_tick;

    logic r_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level;
    adsr_pkg::t_phase     r_out_phase;

    logic w_in_fire;
    logic w_div_start;
    logic w_commit;
    logic w_out_free;

    logic                  w_div_busy;
    logic                  w_div_done;
    logic [DW-1:0]         w_quotient;
    logic [LEVEL_BITS-1:0] w_span;
    logic [TIME_BITS-1:0]  w_time_sel;
    logic [TIME_BITS-1:0]  w_divisor;
    logic [DW-1:0]         w_prod;
    logic [LEVEL_BITS-1:0] w_step;

    adsr_pkg::t_phase      w_gate_phase;
    adsr_pkg::t_phase      n_phase;
    logic [LEVEL_BITS-1:0] n_level;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_in_fire  = i_req.valid && i_req.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            adsr_pkg::SEQ_IDLE:  if (i_req.valid) n_state = adsr_pkg::SEQ_MUL;
            adsr_pkg::SEQ_MUL:   n_state = adsr_pkg::SEQ_DIV;
            adsr_pkg::SEQ_DIV:   if (w_div_done) n_state = adsr_pkg::SEQ_APPLY;
            adsr_pkg::SEQ_APPLY: if (w_out_free) n_state = adsr_pkg::SEQ_IDLE;
            default:             n_state = adsr_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_div_start = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            adsr_pkg::SEQ_IDLE:  i_req.ready = 1'b1;
            adsr_pkg::SEQ_MUL:   w_div_start = 1'b1;
            adsr_pkg::SEQ_DIV:   ;
            adsr_pkg::SEQ_APPLY: w_commit = w_out_free;
            default:             ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adsr_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Gate decision: restart attack from idle or release, enter release on a
    // low gate from any active phase
    always_comb begin
        w_gate_phase = r_phase;
        if (i_req.gate) begin
            if (r_phase == adsr_pkg::PH_IDLE || r_phase == adsr_pkg::PH_RELEASE) begin
                w_gate_phase = adsr_pkg::PH_ATTACK;
            end
        end else if (r_phase != adsr_pkg::PH_IDLE && r_phase != adsr_pkg::PH_RELEASE) begin
            w_gate_phase = adsr_pkg::PH_RELEASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_work_phase <= w_gate_phase;
            r_tick       <= i_req.tick_time;
        end
    end

    // Span and duration of the active slope; idle and sustain divide zero
    always_comb begin
        case (r_work_phase)
            adsr_pkg::PH_ATTACK: begin
                w_span     = FullScale;
                w_time_sel = r_attack_time;
            end
            adsr_pkg::PH_DECAY: begin
                w_span     = (r_peak >= r_sustain) ? (r_peak - r_sustain)
                                                   : (r_sustain - r_peak);
                w_time_sel = r_decay_time;
            end
            adsr_pkg::PH_RELEASE: begin
                w_span     = FullScale;
                w_time_sel = r_release_time;
            end
            default: begin
                w_span     = '0;
                w_time_sel = r_attack_time;
            end
        endcase
        w_divisor = (w_time_sel < MinTime) ? MinTime : w_time_sel;
        w_prod    = {{LEVEL_BITS{1'b0}}, r_tick} * {{TB{1'b0}}, w_span};
    end

    // The product is registered inside the divider on its start cycle
    adsr_div #(
        .DW (DW),
        .VW (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Clamp the step to full scale; every use saturates there anyway
    assign w_step = (|w_quotient[DW-1:LEVEL_BITS]) ? FullScale
                                                   : w_quotient[LEVEL_BITS-1:0];

    // Apply one step of the active phase
    always_comb begin
        logic [LEVEL_BITS:0] sum;
        sum     = {1'b0, r_level} + {1'b0, w_step};
        n_level = r_level;
        n_phase = r_work_phase;
        case (r_work_phase)
            adsr_pkg::PH_ATTACK: begin
                n_level = sum[LEVEL_BITS] ? FullScale : sum[LEVEL_BITS-1:0];
                if (n_level >= r_peak) begin
                    n_level = r_peak;
                    n_phase = adsr_pkg::PH_DECAY;
                end
            end
            adsr_pkg::PH_DECAY: begin
                if (r_level > r_sustain) begin
                    n_level = (w_step >= r_level) ? '0 : (r_level - w_step);
                    if (n_level <= r_sustain) begin
                        n_level = r_sustain;
                        n_phase = adsr_pkg::PH_SUSTAIN;
                    end
                end else if (r_level < r_sustain) begin
                    n_level = sum[LEVEL_BITS-1:0];
                    if (sum >= {1'b0, r_sustain}) begin
                        n_level = r_sustain;
                        n_phase = adsr_pkg::PH_SUSTAIN;
                    end
                end else begin
                    n_phase = adsr_pkg::PH_SUSTAIN;
                end
            end
            adsr_pkg::PH_SUSTAIN: begin
                n_level = r_sustain;
            end
            adsr_pkg::PH_RELEASE: begin
                if (w_step >= r_level) begin
                    n_level = '0;
                    n_phase = adsr_pkg::PH_IDLE;
                end else begin
                    n_level = r_level - w_step;
                end
            end
            default: begin
                n_level = '0;
                n_phase = adsr_pkg::PH_IDLE;
            end
        endcase
    end

    // Commit state and load the output register together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= adsr_pkg::PH_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_phase     <= n_phase;
                r_level     <= n_level;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_level <= n_level;
            r_out_phase <= n_phase;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.level = r_out_level;
    assign o_rsp.phase = r_out_phase;

    // ---------------- assertions ----------------
    `ADSR_ASSERT_IMP(a_idle_div_quiet, i_clk, i_rst_n, r_state == adsr_pkg::SEQ_IDLE,
        !w_div_busy, "divider busy while sequencer idle")
    `ADSR_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, w_div_done,
        r_state == adsr_pkg::SEQ_DIV, "divider finished outside the divide state")
    `ADSR_ASSERT_NXT(a_idle_is_zero, i_clk, i_rst_n,
        w_commit && n_phase == adsr_pkg::PH_IDLE, r_level == '0,
        "idle phase committed with a nonzero level")

endmodule

### tb/adsr_envelope_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ADSR envelope generator: watches the configuration port
// and the request and result channels, predicts level and phase per tick and
// counts mismatches. Depends on adsr_pkg, adsr_in_if and adsr_out_if.

module adsr_envelope_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [23:0]                       i_cfg_data,
    adsr_in_if                                i_req,
    adsr_out_if                               i_rsp,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);

    localparam logic [15:0] FULL_LEVEL = '1;

    typedef struct packed {
        logic [15:0]      level;
        adsr_pkg::t_phase phase;
    } t_envelope_point;

    t_envelope_point expected_points[$];

    logic [23:0]      attack_us;
    logic [23:0]      decay_us;
    logic [23:0]      release_us;
    logic [15:0]      sustain_lvl;
    logic [15:0]      peak_lvl;
    adsr_pkg::t_phase env_phase;
    logic [15:0]      env_level;

    function automatic longint unsigned ramp_step(
        input logic [adsr_pkg::TICK_BITS-1:0] tick,
        input logic [15:0] span,
        input logic [23:0] dur);
        longint unsigned t;
        longint unsigned s;
        longint unsigned d;
        t = tick;
        s = span;
        d = dur;
        if (d < adsr_pkg::MIN_TIME_US) d = adsr_pkg::MIN_TIME_US;
        return (t * s) / d;
    endfunction

    task automatic advance_envelope(input logic gate,
                                    input logic [adsr_pkg::TICK_BITS-1:0] tick);
        longint unsigned lv;
        longint unsigned st;
        longint unsigned sus;
        longint unsigned pk;
        adsr_pkg::t_phase ph;
        t_envelope_point  point;
        lv  = env_level;
        ph  = env_phase;
        sus = sustain_lvl;
        pk  = peak_lvl;
        if (gate) begin
            if (ph == adsr_pkg::PH_IDLE || ph == adsr_pkg::PH_RELEASE) ph = adsr_pkg::PH_ATTACK;
        end else if (ph != adsr_pkg::PH_IDLE && ph != adsr_pkg::PH_RELEASE) begin
            ph = adsr_pkg::PH_RELEASE;
        end
        case (ph)
            adsr_pkg::PH_ATTACK: begin
                lv = lv + ramp_step(tick, FULL_LEVEL, attack_us);
                if (lv > FULL_LEVEL) lv = FULL_LEVEL;
                if (lv >= pk) begin
                    lv = pk;
                    ph = adsr_pkg::PH_DECAY;
                end
            end
            adsr_pkg::PH_DECAY: begin
                st = ramp_step(tick, (pk >= sus) ? peak_lvl - sustain_lvl
                                                 : sustain_lvl - peak_lvl, decay_us);
                if (lv > sus) begin
                    lv = (st >= lv) ? 0 : lv - st;
                    if (lv <= sus) begin
                        lv = sus;
                        ph = adsr_pkg::PH_SUSTAIN;
                    end
                end else if (lv < sus) begin
                    lv = lv + st;
                    if (lv >= sus) begin
                        lv = sus;
                        ph = adsr_pkg::PH_SUSTAIN;
                    end
                end else begin
                    ph = adsr_pkg::PH_SUSTAIN;
                end
            end
            adsr_pkg::PH_SUSTAIN: lv = sus;
            adsr_pkg::PH_RELEASE: begin
                st = ramp_step(tick, FULL_LEVEL, release_us);
                if (st >= lv) begin
                    lv = 0;
                    ph = adsr_pkg::PH_IDLE;
                end else begin
                    lv = lv - st;
                end
            end
            default: begin
                lv = 0;
                ph = adsr_pkg::PH_IDLE;
            end
        endcase
        env_level   = lv[15:0];
        env_phase   = ph;
        point.level = env_level;
        point.phase = env_phase;
        expected_points.insert(expected_points.size(), point);
    endtask

    task automatic check_result();
        t_envelope_point want;
        if (expected_points.size() == 0) begin
            o_fail_count++;
            $display("%0t unexpected result: expected none, got level %0d phase %0d",
                     $time, i_rsp.level, i_rsp.phase);
        end else begin
            want = expected_points.pop_front();
            o_checked++;
            if (i_rsp.level !== want.level || i_rsp.phase !== want.phase) begin
                o_fail_count++;
                $display("%0t mismatch: expected level %0d phase %0d, %s %0d phase %0d",
                         $time, want.level, want.phase, "got level",
                         i_rsp.level, i_rsp.phase);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attack_us    = 24'd10000;
            decay_us     = 24'd100000;
            sustain_lvl  = 16'd45875;
            release_us   = 24'd200000;
            peak_lvl     = 16'd65535;
            env_phase    = adsr_pkg::PH_IDLE;
            env_level    = '0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    adsr_pkg::CFG_ATTACK_TIME:   attack_us   = i_cfg_data;
                    adsr_pkg::CFG_DECAY_TIME:    decay_us    = i_cfg_data;
                    adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_lvl = i_cfg_data[15:0];
                    adsr_pkg::CFG_RELEASE_TIME:  release_us  = i_cfg_data;
                    adsr_pkg::CFG_PEAK_LEVEL:    peak_lvl    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // results leave at least a full computation after their request,
            // so retire before predicting the request taken at this edge
            if (i_rsp.valid && i_rsp.ready) check_result();
            if (i_req.valid && i_req.ready) advance_envelope(i_req.gate, i_req.tick_time);
        end
        o_pending = expected_points.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the ADSR envelope generator testbench: clock, reset, stimulus and verdict.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if, the generator RTL and the checker.

module testbench;

    localparam int LEVEL_BITS       = 16;
    localparam int TIME_BITS        = 24;
    localparam int LONG_HOLD_CYCLES = 400;  // long enough to fill both internal slots
    localparam int DRAIN_CYCLES     = 60;   // idle wait after the last drain, before the verdict
    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 100;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              cfg_we;
    logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_idx;
    logic [TIME_BITS-1:0]              cfg_data;

    int fail_count;
    int pending;
    int checked;
    int settings_count;

    // idling switches for the two sides, and the one-shot long stall request
    bit req_idling;
    bit rsp_idling;
    bit long_hold_req;

    adsr_in_if                               req_if();
    adsr_out_if #(.LEVEL_BITS(LEVEL_BITS))   rsp_if();

    adsr_envelope_generator #(
        .LEVEL_BITS (LEVEL_BITS),
        .TIME_BITS  (TIME_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    adsr_envelope_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: report a failure and end the run after this delay.
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Result side: hold ready low in random bursts, or for one long stretch
    // when asked, counting the stall here so the sender keeps pushing.
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                rsp_if.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt = LONG_HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(1, 15) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Write one register; call only while no request is in flight.
    task automatic write_reg(input logic [adsr_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [TIME_BITS-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Offer one tick request and return in the step where it was taken.
    // Valid stays high on return so back-to-back requests need no extra edge.
    task automatic send_tick(input logic gate, input logic [adsr_pkg::TICK_BITS-1:0] tick);
        if (req_idling && $urandom_range(0, 3) == 0) begin
            req_if.valid     <= 1'b0;
            req_if.gate      <= 1'($urandom);
            req_if.tick_time <= adsr_pkg::TICK_BITS'($urandom);
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.gate      <= gate;
        req_if.tick_time <= tick;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid and wait until every request has come back as a result.
    task automatic drain();
        req_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [TIME_BITS-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TIME_BITS'($urandom_range(1, adsr_pkg::MIN_TIME_US - 1));
            2:       return TIME_BITS'(adsr_pkg::MIN_TIME_US);
            3:       return '1;
            4:       return TIME_BITS'($urandom);
            default: return TIME_BITS'($urandom_range(adsr_pkg::MIN_TIME_US, 20000));
        endcase
    endfunction

    // Level registers are narrower than the write bus: put junk in the upper byte.
    function automatic logic [TIME_BITS-1:0] pick_level();
        logic [LEVEL_BITS-1:0] lvl;
        case ($urandom_range(0, 5))
            0:       lvl = '0;
            1:       lvl = '1;
            default: lvl = LEVEL_BITS'($urandom);
        endcase
        return {8'($urandom), lvl};
    endfunction

    // Mostly ticks short against the ramp times, so phases take several steps.
    function automatic logic [adsr_pkg::TICK_BITS-1:0] pick_tick();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return adsr_pkg::TICK_BITS'($urandom);
            3, 4:    return adsr_pkg::TICK_BITS'($urandom_range(0, 20000));
            default: return adsr_pkg::TICK_BITS'($urandom_range(0, 3000));
        endcase
    endfunction

    // One note: gate held for a while, then released. A few notes get a random
    // gate on every tick to break the usual phase order.
    task automatic play_note(inout int budget);
        int  hold_n;
        int  rel_n;
        bit  broken;
        hold_n = $urandom_range(1, 24);
        rel_n  = $urandom_range(1, 16);
        broken = ($urandom_range(0, 99) < 15);
        repeat (hold_n) send_tick(broken ? 1'($urandom) : 1'b1, pick_tick());
        repeat (rel_n)  send_tick(broken ? 1'($urandom) : 1'b0, pick_tick());
        budget -= hold_n + rel_n;
    endtask

    // Load all five registers: all zero, all ones, or random picks. Also poke
    // an index past the last register, which must change nothing.
    task automatic load_settings(input int mode);
        if (mode == 0) begin
            write_reg(adsr_pkg::CFG_ATTACK_TIME, '0);
            write_reg(adsr_pkg::CFG_DECAY_TIME, '0);
            write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, '0);
            write_reg(adsr_pkg::CFG_RELEASE_TIME, '0);
            write_reg(adsr_pkg::CFG_PEAK_LEVEL, '0);
        end else if (mode == 1) begin
            write_reg(adsr_pkg::CFG_ATTACK_TIME, '1);
            write_reg(adsr_pkg::CFG_DECAY_TIME, '1);
            write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, '1);
            write_reg(adsr_pkg::CFG_RELEASE_TIME, '1);
            write_reg(adsr_pkg::CFG_PEAK_LEVEL, '1);
        end else begin
            write_reg(adsr_pkg::CFG_ATTACK_TIME, pick_time());
            write_reg(adsr_pkg::CFG_DECAY_TIME, pick_time());
            write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, pick_level());
            write_reg(adsr_pkg::CFG_RELEASE_TIME, pick_time());
            write_reg(adsr_pkg::CFG_PEAK_LEVEL, pick_level());
        end
        write_reg(adsr_pkg::CFG_IDX_BITS'($urandom_range(int'(adsr_pkg::CFG_PEAK_LEVEL) + 1,
                                                         (1 << adsr_pkg::CFG_IDX_BITS) - 1)),
                  TIME_BITS'($urandom));
        settings_count++;
    endtask

    initial begin
        int budget;
        // drive every input to a known value before the first edge
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        req_if.valid     <= 1'b0;
        req_if.gate      <= 1'b0;
        req_if.tick_time <= '0;
        req_idling       = 1'b1;
        rsp_idling       = 1'b1;
        long_hold_req    = 1'b0;
        settings_count   = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, starting from the reset settings ----
        // idle with gate low stays at zero, whatever the tick
        send_tick(1'b0, '0);
        send_tick(1'b0, '1);
        // attack from zero, a partial step, then a huge tick clamps at the peak
        send_tick(1'b1, '0);
        send_tick(1'b1, 20'd1000);
        send_tick(1'b1, '1);
        // decay toward sustain, then overshoot lands exactly on it
        send_tick(1'b1, 20'd10000);
        send_tick(1'b1, '1);
        send_tick(1'b1, '0);
        // release partway, retrigger from release, release again with no time
        send_tick(1'b0, 20'd20000);
        send_tick(1'b1, 20'd100);
        send_tick(1'b0, '0);
        drain();

        // retrigger above the peak: clamp at once, then decay rises to sustain
        // (upper byte of the write must be masked off)
        write_reg(adsr_pkg::CFG_PEAK_LEVEL, 24'hAB03E8);
        send_tick(1'b1, '0);
        send_tick(1'b1, 20'd50000);
        send_tick(1'b1, '1);
        drain();

        // sustain tracks a changed sustain level
        write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, 24'hFF2EE0);
        send_tick(1'b1, '0);
        drain();

        // peak equal to sustain: decay sees level == sustain and goes straight
        // to sustain; attack time of zero behaves as the floor
        write_reg(adsr_pkg::CFG_PEAK_LEVEL, 24'h002EE0);
        write_reg(adsr_pkg::CFG_ATTACK_TIME, '0);
        send_tick(1'b0, '0);
        send_tick(1'b1, '0);
        send_tick(1'b1, '0);
        drain();

        // release reaching zero goes idle in the same tick; then an unused
        // index and the longest attack time
        write_reg(adsr_pkg::CFG_RELEASE_TIME, '0);
        write_reg(adsr_pkg::CFG_IDX_BITS'(int'(adsr_pkg::CFG_PEAK_LEVEL) + 1), '1);
        send_tick(1'b0, '1);
        send_tick(1'b0, 20'd5);
        drain();
        write_reg(adsr_pkg::CFG_ATTACK_TIME, '1);
        send_tick(1'b1, '1);
        send_tick(1'b1, 20'h5A5A5);
        drain();
        settings_count++;

        // ---- random part: several register settings, notes with random content ----
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_settings(p);
            if (p == RANDOM_PHASES - 1) begin
                // no idling at all on the last stretch
                req_idling = 1'b0;
                rsp_idling = 1'b0;
            end
            if (p == 3) begin
                // stall the result side for a long time while requests keep
                // coming back to back, so the block has to hold its input off
                req_idling    = 1'b0;
                long_hold_req = 1'b1;
                repeat (12) send_tick(1'($urandom), pick_tick());
                req_idling    = 1'b1;
            end
            budget = ITEMS_PER_PHASE;
            while (budget > 0) play_note(budget);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d tick results checked over %0d register settings,",
                 checked, settings_count);
        $display("summary: zero/max/random ramp times and levels, random stalls and one long stall");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
